// ===== src/spmg_pkg.sv =====
// Package for the passthrough gate: item and result types, codes, constants
// and the open and close byte sequences.
// No dependencies.
`default_nettype none

package spmg_pkg;

  localparam logic [4:0] OPEN_LEN     = 5'd19;
  localparam logic [4:0] CLOSE_LEN    = 5'd22;
  localparam logic [2:0] SETTLE_TICKS = 3'd5;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_UNLOCK = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CODE_NONE   = 2'd0,
    CODE_PACKET = 2'd1,
    CODE_CLOSE  = 2'd2
  } code_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       gimbal_found;
    logic       vehicle_armed;
    logic       lock_granted;
  } item_t;

  typedef struct packed {
    logic [1:0] handler_code;
    logic       forward_valid;
    logic [7:0] forward_byte;
    logic       send_ack;
    logic       link_locked;
  } result_t;

  function automatic logic [7:0] open_byte(input logic [4:0] pos);
    case (pos)
      5'd0:    open_byte = 8'hFA;
      5'd1:    open_byte = 8'h0E;
      5'd2:    open_byte = 8'hD2;
      5'd3:    open_byte = "S";
      5'd4:    open_byte = "T";
      5'd5:    open_byte = "O";
      5'd6:    open_byte = "R";
      5'd7:    open_byte = "M";
      5'd8:    open_byte = "3";
      5'd9:    open_byte = "2";
      5'd10:   open_byte = "C";
      5'd11:   open_byte = "O";
      5'd12:   open_byte = "N";
      5'd13:   open_byte = "N";
      5'd14:   open_byte = "E";
      5'd15:   open_byte = "C";
      5'd16:   open_byte = "T";
      5'd17:   open_byte = 8'h33;
      5'd18:   open_byte = 8'h34;
      default: open_byte = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] close_byte(input logic [4:0] pos);
    case (pos)
      5'd0:    close_byte = 8'hF9;
      5'd1:    close_byte = 8'h11;
      5'd2:    close_byte = 8'hD2;
      5'd3:    close_byte = "S";
      5'd4:    close_byte = "T";
      5'd5:    close_byte = "O";
      5'd6:    close_byte = "R";
      5'd7:    close_byte = "M";
      5'd8:    close_byte = "3";
      5'd9:    close_byte = "2";
      5'd10:   close_byte = "D";
      5'd11:   close_byte = "I";
      5'd12:   close_byte = "S";
      5'd13:   close_byte = "C";
      5'd14:   close_byte = "O";
      5'd15:   close_byte = "N";
      5'd16:   close_byte = "N";
      5'd17:   close_byte = "E";
      5'd18:   close_byte = "C";
      5'd19:   close_byte = "T";
      5'd20:   close_byte = 8'h33;
      5'd21:   close_byte = 8'h34;
      default: close_byte = 8'h00;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== src/spmg_step.sv =====
// Gate state (lock, shared match position, settle count) and the logic that
// turns one item into one result.
// Depends on spmg_pkg.
`default_nettype none

module spmg_step import spmg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    fire,
  input  wire item_t   item,
  input  wire logic    block_when_armed,
  output result_t      res
);

  logic       locked, locked_next;
  logic [4:0] match_pos, match_pos_next;
  logic [2:0] settle_count, settle_count_next;

  logic [4:0] open_start, open_pos;
  logic       open_done;
  logic [4:0] close_start, close_pos;
  logic       close_done;
  logic       fwd;

  // first byte of a sequence restarts the match
  always_comb begin
    open_start = (item.data_byte == open_byte(5'd0)) ? 5'd0 : match_pos;
    if (open_start < OPEN_LEN && item.data_byte == open_byte(open_start)) begin
      open_pos  = open_start + 5'd1;
      open_done = (open_start + 5'd1) == OPEN_LEN;
    end else begin
      open_pos  = 5'd0;
      open_done = 1'b0;
    end
    close_start = (item.data_byte == close_byte(5'd0)) ? 5'd0 : match_pos;
    if (close_start < CLOSE_LEN && item.data_byte == close_byte(close_start)) begin
      close_pos  = close_start + 5'd1;
      close_done = (close_start + 5'd1) == CLOSE_LEN;
    end else begin
      close_pos  = 5'd0;
      close_done = 1'b0;
    end
  end

  always_comb begin
    locked_next       = locked;
    match_pos_next    = match_pos;
    settle_count_next = settle_count;
    res               = '0;
    fwd               = 1'b0;
    case (item.kind)
      KIND_TICK: begin
        if (item.gimbal_found && locked && settle_count != 3'd0) begin
          settle_count_next = settle_count - 3'd1;
          res.send_ack      = (settle_count == 3'd1);
        end
      end
      KIND_BYTE, KIND_UNLOCK: begin
        if (item.gimbal_found) begin
          if (block_when_armed && item.vehicle_armed) begin
            match_pos_next = 5'd0;
            if (locked) begin
              locked_next      = 1'b0;
              res.handler_code = CODE_CLOSE;
            end
          end else if (item.kind == KIND_UNLOCK) begin
            locked_next      = 1'b0;
            res.handler_code = CODE_CLOSE;
          end else if (!locked) begin
            if (open_done && item.lock_granted) begin
              match_pos_next    = 5'd0;
              locked_next       = 1'b1;
              settle_count_next = SETTLE_TICKS;
            end else begin
              match_pos_next = open_pos; // stays at full length without grant
            end
          end else begin
            res.handler_code = CODE_PACKET;
            fwd              = (settle_count == 3'd0);
            if (close_done) begin
              match_pos_next   = 5'd0;
              locked_next      = 1'b0;
              res.handler_code = CODE_CLOSE;
            end else begin
              match_pos_next = close_pos;
            end
          end
        end
      end
      default: ;
    endcase
    res.forward_valid = fwd;
    res.forward_byte  = fwd ? item.data_byte : 8'h00;
    res.link_locked   = locked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      locked       <= 1'b0;
      match_pos    <= 5'd0;
      settle_count <= 3'd0;
    end else if (fire) begin
      locked       <= locked_next;
      match_pos    <= match_pos_next;
      settle_count <= settle_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/serial_passthrough_magic_gate.sv =====
// An accepted item passes through the input register and then the result
// register. Throughput: one item per cycle, stalled only by out_stall.
// Synchronous reset clears the valid flags of both stages, the lock, the
// match position, the settle count and block_when_armed.
// Top level of the passthrough gate; depends on spmg_pkg and spmg_step.
`default_nettype none

module serial_passthrough_magic_gate import spmg_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] kind,
  input  wire logic [7:0] data_byte,
  input  wire logic       gimbal_found,
  input  wire logic       vehicle_armed,
  input  wire logic       lock_granted,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      handler_code,
  output logic            forward_valid,
  output logic [7:0]      forward_byte,
  output logic            send_ack,
  output logic            link_locked,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data
);

  logic    s1_valid;
  item_t   s1_item;
  logic    advance;
  logic    fire;
  logic    block_when_armed;
  result_t res;
  result_t out_res;

  assign advance   = !out_valid || !out_stall;
  assign fire      = s1_valid && advance;
  assign in_stall  = s1_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
      block_when_armed <= 1'b0;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      if (advance) out_valid <= s1_valid;
      if (cfg_valid && cfg_ready) block_when_armed <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item.kind          <= kind;
      s1_item.data_byte     <= data_byte;
      s1_item.gimbal_found  <= gimbal_found;
      s1_item.vehicle_armed <= vehicle_armed;
      s1_item.lock_granted  <= lock_granted;
    end
    if (fire) out_res <= res;
  end

  spmg_step u_step (
    .clk              (clk),
    .rst              (rst),
    .fire             (fire),
    .item             (s1_item),
    .block_when_armed (block_when_armed),
    .res              (res)
  );

  assign handler_code  = out_res.handler_code;
  assign forward_valid = out_res.forward_valid;
  assign forward_byte  = out_res.forward_byte;
  assign send_ack      = out_res.send_ack;
  assign link_locked   = out_res.link_locked;

endmodule

`default_nettype wire
